### src/rcq_pkg.sv
package rcq_pkg;

  localparam int unsigned PIN_W   = 6;
  localparam int unsigned PAT_W   = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  // Command bits 1:0
  localparam logic [1:0] MODE_STOP = 2'b00;
  localparam logic [1:0] MODE_FWD  = 2'b01;
  localparam logic [1:0] MODE_REV  = 2'b10;

  // Command bits 3:2 value that drives the port-select line
  localparam logic [1:0] PORT_ALT = 2'b10;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] pending;
    logic [PAT_W-1:0]  last_pattern;
    logic [CNT_W-1:0]  match_count;
    logic              select;
  } rcq_state_t;

  typedef struct packed {
    logic              port_select;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] command_inverse;
    logic [BYTE_W-1:0] command_byte;
  } rcq_result_t;

endpackage

### src/rcq_decide.sv
module rcq_decide #(
  parameter int unsigned QUALIFY_COUNT = 4
) (
  input  rcq_pkg::rcq_state_t         state,
  input  logic [rcq_pkg::PIN_W-1:0]   pin_sample,
  input  logic                        tx_busy,
  output rcq_pkg::rcq_state_t         state_nxt,
  output rcq_pkg::rcq_result_t        result
);
  import rcq_pkg::*;

  localparam logic [CNT_W-1:0] QUAL = CNT_W'(QUALIFY_COUNT);

  logic [1:0]       port;
  logic [PAT_W-1:0] pat;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       mode;
  logic [1:0]       req;
  logic [BYTE_W-1:0] st;

  assign port = state.command[3:2];
  assign pat  = pin_sample[PAT_W-1:0];
  assign req  = ~pin_sample[5:4];

  always_comb begin
    state_nxt = state;
    cnt       = state.match_count;
    mode      = MODE_STOP;
    st        = state.command;
    if (state.command[1:0] != MODE_STOP) begin
      state_nxt.select = (port == PORT_ALT);
      if (pat == state.last_pattern) begin
        cnt = (state.match_count >= QUAL) ? QUAL : state.match_count + CNT_W'(1);
      end else begin
        cnt = CNT_W'(1);
        state_nxt.last_pattern = pat;
      end
      state_nxt.match_count = cnt;
      // Prioritized mapping: stop, then run, then fault overrides back to forward
      if (!pat[0]) mode = MODE_FWD;
      if (!pat[1]) mode = MODE_REV;
      if ((pat[3:2] != 2'b00) && (mode != MODE_STOP)) mode = MODE_FWD;
      if (cnt == QUAL) begin
        st = {4'b0000, port, mode};
      end
    end else begin
      // Exactly one fan request picks the unit and starts forward run
      if (req == 2'b01 || req == 2'b10) begin
        st = {4'b0000, req, MODE_FWD};
      end
    end
    state_nxt.pending = st;
    if (!tx_busy) state_nxt.command = st;
  end

  always_comb begin
    result.command_byte    = state_nxt.command;
    result.command_inverse = ~state_nxt.command;
    result.status_byte     = state_nxt.pending;
    result.port_select     = state_nxt.select;
  end

endmodule

### src/run_command_qualifier.sv
// Channel | Dir | tdata (low bit up)                          | tuser
// in_     | in  | [5:0] pin_sample, [7:6] zero                | [0] tx_busy
// out_    | out | [7:0] command_byte, [15:8] command_inverse, | none
//         |     | [23:16] status_byte, [24] port_select,      |
//         |     | [31:25] zero                                |
//
// One transaction per cycle sustained while the receiver keeps out_tready
// high; the result is registered behind the input register: decide logic
// feeds the result register, where the qualifier state also updates.
// Synchronous active-low reset clears both valid flags and the qualifier state.
// A stalled result holds the output register; the input register keeps
// accepting while the result register has room or is being drained.
module run_command_qualifier #(
  parameter int unsigned QUALIFY_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rcq_pkg::IN_TDATA_W-1:0]      in_tdata,  // [5:0] pin_sample
  input  logic                                in_tuser,  // [0] tx_busy
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] command_byte, [15:8] command_inverse, [23:16] status_byte, [24] port_select
  output logic [rcq_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import rcq_pkg::*;

  logic              in_valid_r;
  logic [PIN_W-1:0]  pins_r;
  logic              busy_r;
  logic              out_valid_r;
  rcq_result_t       result_r;
  rcq_result_t       result_nxt;
  rcq_state_t        state_r;
  rcq_state_t        state_nxt;
  logic              out_room;
  logic              advance;

  assign out_room  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_room;
  assign in_tready = !in_valid_r || advance;

  rcq_decide #(
    .QUALIFY_COUNT(QUALIFY_COUNT)
  ) u_decide (
    .state      (state_r),
    .pin_sample (pins_r),
    .tx_busy    (busy_r),
    .state_nxt  (state_nxt),
    .result     (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pins_r <= in_tdata[PIN_W-1:0];
      busy_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (out_room) out_valid_r <= in_valid_r;
      if (advance)  state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result_r <= result_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(rcq_result_t)){1'b0}}, result_r};

`ifndef ASSERT_OFF
  a_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:8] == ~out_tdata[7:0]))
    else $error("command inverse mismatch");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.match_count <= CNT_W'(QUALIFY_COUNT))
    else $error("match count above qualify count");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && busy_r) |=> $stable(state_r.command))
    else $error("command changed while transmitter busy");

  a_status_track: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (state_r.pending == result_r.status_byte))
    else $error("status byte differs from pending status");
`endif

endmodule

### sim/run_command_qualifier_chk.sv
module run_command_qualifier_chk #(
  parameter int unsigned QUALIFY_COUNT = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rcq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rcq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              outstanding
);
  import rcq_pkg::*;

  rcq_result_t       want_results[$];

  logic [BYTE_W-1:0] cmd_q;
  logic [BYTE_W-1:0] pend_q;
  logic [PAT_W-1:0]  pat_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              sel_q;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Advance the qualifier state by one tick and form the result it reports.
  task automatic qualify_tick(input logic [PIN_W-1:0] pins, input logic busy,
                              output rcq_result_t res);
    logic [BYTE_W-1:0] st;
    logic [1:0]        port;
    logic [PAT_W-1:0]  pat;
    logic [1:0]        req;
    port = cmd_q[3:2];
    pat  = pins[PAT_W-1:0];
    if (cmd_q[1:0] != MODE_STOP) begin
      sel_q = (port == PORT_ALT);
      if (pat == pat_q) begin
        if (cnt_q < QUALIFY_COUNT) cnt_q = cnt_q + 1'b1;
      end else begin
        cnt_q = CNT_W'(1);
        pat_q = pat;
      end
      if (cnt_q == QUALIFY_COUNT) begin
        st = {4'h0, port, MODE_STOP};
        if (!pat[0]) st[1:0] = MODE_FWD;
        if (!pat[1]) st[1:0] = MODE_REV;
        // a fault pin high knocks any running mode back to forward
        if (pat[3:2] != 2'b00 && st[1:0] != MODE_STOP) st[1:0] = MODE_FWD;
      end else begin
        st = cmd_q;
      end
    end else begin
      // fan requests are active low: pin 4 asks for unit one, pin 5 for unit two
      req = ~pins[5:4];
      if (req == 2'b01 || req == 2'b10) st = {4'h0, req, MODE_FWD};
      else st = cmd_q;
    end
    pend_q = st;
    if (!busy) cmd_q = st;
    res.command_byte    = cmd_q;
    res.command_inverse = ~cmd_q;
    res.status_byte     = pend_q;
    res.port_select     = sel_q;
  endtask

  always @(posedge clk) begin : watch
    rcq_result_t got;
    rcq_result_t want;
    if (!rst_n) begin
      cmd_q  = '0;
      pend_q = '0;
      pat_q  = '0;
      cnt_q  = '0;
      sel_q  = 1'b0;
      want_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = rcq_result_t'(out_tdata[$bits(rcq_result_t)-1:0]);
        if (want_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata, 0);
        end else begin
          want = want_results.pop_front();
          if (got.command_byte != want.command_byte)
            report_mismatch("command_byte", got.command_byte, want.command_byte);
          if (got.command_inverse != want.command_inverse)
            report_mismatch("command_inverse", got.command_inverse, want.command_inverse);
          if (got.status_byte != want.status_byte)
            report_mismatch("status_byte", got.status_byte, want.status_byte);
          if (got.port_select != want.port_select)
            report_mismatch("port_select", got.port_select, want.port_select);
        end
      end
      if (in_tvalid && in_tready) begin
        qualify_tick(in_tdata[PIN_W-1:0], in_tuser, want);
        want_results.push_back(want);
      end
    end
    outstanding = want_results.size();
  end

endmodule

### sim/run_command_qualifier_tb.sv
module run_command_qualifier_tb;
  import rcq_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [5:0] pin_sample, [7:6] zero
  logic                   in_tuser;   // [0] tx_busy
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] command_byte, [15:8] command_inverse,
                                      // [23:16] status_byte, [24] port_select

  int mismatches;
  int outstanding;
  int idle_pct;
  int stall_pct;
  int hold_left;

  // bit 6 is tx_busy, bits 5:0 the pin sample
  logic [6:0] directed[$] = '{
    7'h3f, 7'h0f, 7'h5f, 7'h2f,
    7'h2e, 7'h2e, 7'h2e, 7'h2e,
    7'h2d, 7'h2d, 7'h2d, 7'h2d,
    7'h25, 7'h25, 7'h25, 7'h25,
    7'h3f, 7'h3f, 7'h3f, 7'h3f,
    7'h1f, 7'h00, 7'h00, 7'h40, 7'h00, 7'h3f
  };

  run_command_qualifier #(.QUALIFY_COUNT(4)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  run_command_qualifier_chk #(.QUALIFY_COUNT(4)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Change knobs on the rising edge, where the receiver never looks at them.
  task automatic set_idling(input int sender, input int receiver);
    in_tvalid <= 1'b0;
    @(posedge clk);
    idle_pct  = sender;
    stall_pct = receiver;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input logic [PIN_W-1:0] pins, input logic busy);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-PIN_W){1'b0}}, pins};
    in_tuser  <= busy;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(negedge clk);
  endtask

  // Mostly runs of one pin pattern, often long enough to qualify, some broken, some noise.
  task automatic run_random(input int n);
    int               left;
    int               len;
    logic [PAT_W-1:0] pat;
    logic [PIN_W-1:0] pins;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 75) begin
        pat = PAT_W'($urandom);
        len = $urandom_range(2, 7);
        repeat (len) begin
          pins = {2'($urandom), pat};
          if ($urandom_range(99) < 5) pins[PAT_W-1:0] = PAT_W'($urandom);
          send_tick(pins, $urandom_range(99) < 20);
          left--;
        end
      end else begin
        send_tick(PIN_W'($urandom), 1'($urandom_range(1)));
        left--;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_tick(directed[i][PIN_W-1:0], directed[i][6]);

    set_idling(0, 0);
    // hold the result side while the sender keeps pushing, so the input stalls
    @(posedge clk);
    hold_left = 80;
    @(negedge clk);
    run_random(425);

    set_idling(68, 0);
    run_random(425);
    drain();

    set_idling(0, 68);
    run_random(425);

    set_idling(33, 33);
    run_random(425);

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### run_command_qualifier.f
src/rcq_pkg.sv
src/rcq_decide.sv
src/run_command_qualifier.sv
sim/run_command_qualifier_chk.sv
sim/run_command_qualifier_tb.sv
